FILE: design/tcda_pkg.sv
// Package for the tilt-corrected distance average block.
// Holds field widths, angle folding constants, the quarter-wave cosine table,
// the sequencer state type and the control bundle. Depends on nothing.
package tcda_pkg;

   localparam int ANGLE_W        = 13;
   localparam int DIST_W         = 16;
   localparam int MEAN_W         = 17;
   localparam int PROJ_W         = 17;
   localparam int WS_W           = 9;
   localparam int COS_W          = 16;
   localparam int COS_IDX_W      = 7;
   localparam int FRAC_W         = 4;
   localparam int MAX_WINDOW_DEF = 256;

   localparam int ANGLE_FULL    = 5760;
   localparam int ANGLE_HALF    = 2880;
   localparam int ANGLE_QUARTER = 1440;
   localparam int COS_LAST_IDX  = 90;

   typedef logic signed [ANGLE_W-1:0] angle_type;
   typedef logic [DIST_W-1:0]         dist_type;
   typedef logic signed [MEAN_W-1:0]  mean_type;
   typedef logic signed [PROJ_W-1:0]  proj_type;
   typedef logic [WS_W-1:0]           ws_type;
   typedef logic [COS_W-1:0]          cos_type;
   typedef logic [COS_IDX_W-1:0]      cos_idx_type;
   typedef logic [FRAC_W-1:0]         frac_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FOLD,
      ST_LERP,
      ST_MUL,
      ST_PROJ,
      ST_ACC,
      ST_ABS,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic req_ready;
      logic capture;
      logic fold;
      logic lerp;
      logic mul_step;
      logic proj;
      logic acc;
      logic abs_load;
      logic div_step;
      logic out_load;
      logic cnt_step;
   } ctrl_type;

   function automatic cos_type cos_lut(input cos_idx_type idx);
      cos_type val;
      unique case (idx)
         7'd0:  val = 16'd32768;  7'd1:  val = 16'd32763;  7'd2:  val = 16'd32748;
         7'd3:  val = 16'd32723;  7'd4:  val = 16'd32688;  7'd5:  val = 16'd32643;
         7'd6:  val = 16'd32588;  7'd7:  val = 16'd32524;  7'd8:  val = 16'd32449;
         7'd9:  val = 16'd32365;  7'd10: val = 16'd32270;  7'd11: val = 16'd32166;
         7'd12: val = 16'd32052;  7'd13: val = 16'd31928;  7'd14: val = 16'd31795;
         7'd15: val = 16'd31651;  7'd16: val = 16'd31499;  7'd17: val = 16'd31336;
         7'd18: val = 16'd31164;  7'd19: val = 16'd30983;  7'd20: val = 16'd30792;
         7'd21: val = 16'd30592;  7'd22: val = 16'd30382;  7'd23: val = 16'd30163;
         7'd24: val = 16'd29935;  7'd25: val = 16'd29698;  7'd26: val = 16'd29452;
         7'd27: val = 16'd29197;  7'd28: val = 16'd28932;  7'd29: val = 16'd28660;
         7'd30: val = 16'd28378;  7'd31: val = 16'd28088;  7'd32: val = 16'd27789;
         7'd33: val = 16'd27482;  7'd34: val = 16'd27166;  7'd35: val = 16'd26842;
         7'd36: val = 16'd26510;  7'd37: val = 16'd26170;  7'd38: val = 16'd25822;
         7'd39: val = 16'd25466;  7'd40: val = 16'd25102;  7'd41: val = 16'd24730;
         7'd42: val = 16'd24351;  7'd43: val = 16'd23965;  7'd44: val = 16'd23571;
         7'd45: val = 16'd23170;  7'd46: val = 16'd22763;  7'd47: val = 16'd22348;
         7'd48: val = 16'd21926;  7'd49: val = 16'd21498;  7'd50: val = 16'd21063;
         7'd51: val = 16'd20622;  7'd52: val = 16'd20174;  7'd53: val = 16'd19720;
         7'd54: val = 16'd19261;  7'd55: val = 16'd18795;  7'd56: val = 16'd18324;
         7'd57: val = 16'd17847;  7'd58: val = 16'd17364;  7'd59: val = 16'd16877;
         7'd60: val = 16'd16384;  7'd61: val = 16'd15886;  7'd62: val = 16'd15384;
         7'd63: val = 16'd14876;  7'd64: val = 16'd14365;  7'd65: val = 16'd13848;
         7'd66: val = 16'd13328;  7'd67: val = 16'd12803;  7'd68: val = 16'd12275;
         7'd69: val = 16'd11743;  7'd70: val = 16'd11207;  7'd71: val = 16'd10668;
         7'd72: val = 16'd10126;  7'd73: val = 16'd9580;   7'd74: val = 16'd9032;
         7'd75: val = 16'd8481;   7'd76: val = 16'd7927;   7'd77: val = 16'd7371;
         7'd78: val = 16'd6813;   7'd79: val = 16'd6252;   7'd80: val = 16'd5690;
         7'd81: val = 16'd5126;   7'd82: val = 16'd4560;   7'd83: val = 16'd3993;
         7'd84: val = 16'd3425;   7'd85: val = 16'd2856;   7'd86: val = 16'd2286;
         7'd87: val = 16'd1715;   7'd88: val = 16'd1144;   7'd89: val = 16'd572;
         default: val = 16'd0;
      endcase
      return val;
   endfunction

endpackage

FILE: design/tcda_if.sv
// Valid/ready channel interfaces for the request and response transactions.
// Depends on tcda_pkg for the payload types.
interface tcda_req_if;
   logic                 valid;
   logic                 ready;
   tcda_pkg::angle_type  angle_deg;
   tcda_pkg::dist_type   distance;

   modport source (output valid, output angle_deg, output distance, input ready);
   modport sink   (input valid, input angle_deg, input distance, output ready);
endinterface

interface tcda_rsp_if;
   logic                 valid;
   logic                 ready;
   tcda_pkg::mean_type   mean_distance;
   logic                 window_full;

   modport source (output valid, output mean_distance, output window_full, input ready);
   modport sink   (input valid, input mean_distance, input window_full, output ready);
endinterface

FILE: design/tilt_corrected_distance_average.sv
// Tilt-corrected distance average: cosine projection, sample ring and serial mean.
// Depends on tcda_pkg and the channel interfaces in tcda_if.sv.
//
//   channel   direction   transfers on          payload
//   req_bus   in          valid && ready        angle_deg, distance
//   rsp_bus   out         valid && ready        mean_distance, window_full
//   csr_*     in          csr_write_enable      window_size (9 bits)
//
// A transaction folds, interpolates, multiplies and accumulates; once the window is
// full it also divides. A bit-serial multiplier of 16 steps forms the
// projection, and a restoring divider of one quotient bit per cycle forms the mean.
// One transaction is worked on at a time; a new one is taken while the previous
// response still waits in the output register. Reset is synchronous and clears the
// window; the response waits in its register for as long as rsp_bus.ready is low.
module tilt_corrected_distance_average #(
   parameter int MAX_WINDOW = tcda_pkg::MAX_WINDOW_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   tcda_req_if.sink             req_bus,
   tcda_rsp_if.source           rsp_bus,
   input  logic                 csr_write_enable,
   input  tcda_pkg::ws_type     csr_write_data
);

   localparam int IDX_W = (MAX_WINDOW > 2) ? $clog2(MAX_WINDOW) : 1;
   localparam int SUM_W = tcda_pkg::PROJ_W + $clog2(MAX_WINDOW);
   localparam int CNT_W = $clog2(SUM_W);

   typedef logic [IDX_W-1:0]        idx_type;
   typedef logic [IDX_W:0]          idx_ext_type;
   typedef logic signed [SUM_W-1:0] sum_type;
   typedef logic [SUM_W-1:0]        mag_type;
   typedef logic [CNT_W-1:0]        cnt_type;

   tcda_pkg::state_type  state_ff, state_in;
   tcda_pkg::ctrl_type   ctrl;

   tcda_pkg::ws_type     ws_ff;
   idx_type              wr_idx_ff;
   logic                 filled_ff;
   sum_type              sum_ff;
   cnt_type              cnt_ff;

   tcda_pkg::angle_type  angle_ff;
   tcda_pkg::dist_type   dist_ff;
   logic                 neg_ff;
   tcda_pkg::cos_idx_type cidx_ff;
   tcda_pkg::frac_type   frac_ff;
   tcda_pkg::dist_type   hi_ff;
   tcda_pkg::cos_type    lo_ff;
   tcda_pkg::proj_type   proj_ff;
   tcda_pkg::proj_type   ring_rd_ff;
   tcda_pkg::ws_type     rem_ff;
   mag_type              quo_ff;

   logic                 rsp_valid_ff;
   tcda_pkg::mean_type   mean_ff;
   logic                 full_ff;

   tcda_pkg::proj_type   sample_ring [MAX_WINDOW];

   logic                 out_free;
   idx_ext_type          idx_next;
   logic                 idx_wrap;
   tcda_pkg::ws_type     ws_clamped;

   logic [tcda_pkg::ANGLE_W-1:0] mag0, mag1, mag2;
   logic                 fold_neg;
   tcda_pkg::cos_idx_type cidx_next;
   logic [20:0]          lerp_sum;
   logic [tcda_pkg::DIST_W:0] mul_sum;
   logic [tcda_pkg::PROJ_W-1:0] proj_mag;
   sum_type              sum_in;
   logic [tcda_pkg::WS_W:0] div_trial;
   logic                 div_bit;
   tcda_pkg::mean_type   quo_low;
   tcda_pkg::mean_type   mean_in;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign idx_next = {1'b0, wr_idx_ff} + idx_ext_type'(1);
   assign idx_wrap = 32'(idx_next) >= 32'(ws_ff);

   always_comb begin
      if (csr_write_data == '0) begin
         ws_clamped = tcda_pkg::ws_type'(1);
      end else if (32'(csr_write_data) > 32'(MAX_WINDOW)) begin
         ws_clamped = tcda_pkg::ws_type'(MAX_WINDOW);
      end else begin
         ws_clamped = csr_write_data;
      end
   end

   // Sequencer: next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tcda_pkg::ST_IDLE: if (req_bus.valid) state_in = tcda_pkg::ST_FOLD;
         tcda_pkg::ST_FOLD: state_in = tcda_pkg::ST_LERP;
         tcda_pkg::ST_LERP: state_in = tcda_pkg::ST_MUL;
         tcda_pkg::ST_MUL: begin
            if (cnt_ff == cnt_type'(tcda_pkg::DIST_W - 1)) state_in = tcda_pkg::ST_PROJ;
         end
         tcda_pkg::ST_PROJ: state_in = tcda_pkg::ST_ACC;
         tcda_pkg::ST_ACC: begin
            state_in = (filled_ff || idx_wrap) ? tcda_pkg::ST_ABS : tcda_pkg::ST_OUT;
         end
         tcda_pkg::ST_ABS: state_in = tcda_pkg::ST_DIV;
         tcda_pkg::ST_DIV: begin
            if (cnt_ff == cnt_type'(SUM_W - 1)) state_in = tcda_pkg::ST_OUT;
         end
         tcda_pkg::ST_OUT: if (out_free) state_in = tcda_pkg::ST_IDLE;
         default: state_in = tcda_pkg::ST_IDLE;
      endcase
   end

   // Sequencer: control outputs.
   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         tcda_pkg::ST_IDLE: begin
            ctrl.req_ready = 1'b1;
            ctrl.capture   = req_bus.valid;
         end
         tcda_pkg::ST_FOLD: ctrl.fold = 1'b1;
         tcda_pkg::ST_LERP: ctrl.lerp = 1'b1;
         tcda_pkg::ST_MUL: begin
            ctrl.mul_step = 1'b1;
            ctrl.cnt_step = (cnt_ff != cnt_type'(tcda_pkg::DIST_W - 1));
         end
         tcda_pkg::ST_PROJ: ctrl.proj = 1'b1;
         tcda_pkg::ST_ACC:  ctrl.acc = 1'b1;
         tcda_pkg::ST_ABS:  ctrl.abs_load = 1'b1;
         tcda_pkg::ST_DIV: begin
            ctrl.div_step = 1'b1;
            ctrl.cnt_step = (cnt_ff != cnt_type'(SUM_W - 1));
         end
         tcda_pkg::ST_OUT:  ctrl.out_load = out_free;
         default: ctrl = '0;
      endcase
   end

   assign req_bus.ready = ctrl.req_ready;

   // Angle folding into the first quadrant.
   always_comb begin
      mag0     = angle_ff[tcda_pkg::ANGLE_W-1] ? (~angle_ff + 1'b1) : angle_ff;
      mag1     = (mag0 > tcda_pkg::ANGLE_W'(tcda_pkg::ANGLE_HALF))
               ? (tcda_pkg::ANGLE_W'(tcda_pkg::ANGLE_FULL) - mag0) : mag0;
      fold_neg = mag1 > tcda_pkg::ANGLE_W'(tcda_pkg::ANGLE_QUARTER);
      mag2     = fold_neg ? (tcda_pkg::ANGLE_W'(tcda_pkg::ANGLE_HALF) - mag1) : mag1;
   end

   assign cidx_next = (cidx_ff < tcda_pkg::cos_idx_type'(tcda_pkg::COS_LAST_IDX))
                    ? (cidx_ff + 1'b1) : tcda_pkg::cos_idx_type'(tcda_pkg::COS_LAST_IDX);
   assign lerp_sum = 21'(tcda_pkg::cos_lut(cidx_ff)) * (21'd16 - 21'(frac_ff))
                   + 21'(tcda_pkg::cos_lut(cidx_next)) * 21'(frac_ff) + 21'd8;

   assign mul_sum  = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, dist_ff} : '0);
   assign proj_mag = {hi_ff, lo_ff[tcda_pkg::COS_W-1]}
                   + tcda_pkg::PROJ_W'(lo_ff[tcda_pkg::COS_W-2]);

   assign sum_in = sum_ff + sum_type'(proj_ff)
                 - (filled_ff ? sum_type'(ring_rd_ff) : sum_type'(0));

   assign div_trial = {rem_ff, quo_ff[SUM_W-1]};
   assign div_bit   = div_trial >= {1'b0, ws_ff};

   assign quo_low = tcda_pkg::mean_type'(quo_ff[tcda_pkg::MEAN_W-1:0]);
   always_comb begin
      if (!filled_ff) begin
         mean_in = '0;
      end else if (sum_ff[SUM_W-1]) begin
         mean_in = -quo_low;
      end else begin
         mean_in = quo_low;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcda_pkg::ST_IDLE;
         ws_ff        <= tcda_pkg::ws_type'(1);
         wr_idx_ff    <= '0;
         filled_ff    <= 1'b0;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= ctrl.cnt_step ? (cnt_ff + 1'b1) : '0;
         if (csr_write_enable) begin
            ws_ff     <= ws_clamped;
            wr_idx_ff <= '0;
            filled_ff <= 1'b0;
            sum_ff    <= '0;
         end else if (ctrl.acc) begin
            sum_ff    <= sum_in;
            wr_idx_ff <= idx_wrap ? '0 : idx_next[IDX_W-1:0];
            if (idx_wrap) filled_ff <= 1'b1;
         end
         if (ctrl.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         angle_ff <= req_bus.angle_deg;
         dist_ff  <= req_bus.distance;
      end
      if (ctrl.fold) begin
         neg_ff  <= fold_neg;
         cidx_ff <= mag2[tcda_pkg::COS_IDX_W+tcda_pkg::FRAC_W-1:tcda_pkg::FRAC_W];
         frac_ff <= mag2[tcda_pkg::FRAC_W-1:0];
      end
      if (ctrl.lerp) begin
         hi_ff <= '0;
         lo_ff <= lerp_sum[19:4];
      end else if (ctrl.mul_step) begin
         hi_ff <= mul_sum[tcda_pkg::DIST_W:1];
         lo_ff <= {mul_sum[0], lo_ff[tcda_pkg::COS_W-1:1]};
      end
      if (ctrl.proj) begin
         proj_ff <= neg_ff ? -tcda_pkg::proj_type'(proj_mag) : tcda_pkg::proj_type'(proj_mag);
      end
      if (ctrl.abs_load) begin
         rem_ff <= '0;
         quo_ff <= sum_ff[SUM_W-1] ? mag_type'(-sum_ff) : mag_type'(sum_ff);
      end else if (ctrl.div_step) begin
         rem_ff <= div_bit ? tcda_pkg::ws_type'(div_trial - {1'b0, ws_ff})
                           : div_trial[tcda_pkg::WS_W-1:0];
         quo_ff <= {quo_ff[SUM_W-2:0], div_bit};
      end
      if (ctrl.out_load) begin
         mean_ff <= mean_in;
         full_ff <= filled_ff;
      end
   end

   always_ff @(posedge clock) begin
      ring_rd_ff <= sample_ring[wr_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (ctrl.acc) begin
         sample_ring[wr_idx_ff] <= proj_ff;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.mean_distance = mean_ff;
   assign rsp_bus.window_full   = full_ff;

   assert property (@(posedge clock) disable iff (reset)
      32'(wr_idx_ff) < 32'(ws_ff))
      else $error("Write index has run past the window size.");

   assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> (!filled_ff && wr_idx_ff == '0 && sum_ff == '0))
      else $error("Window was not emptied by a register write.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcda_pkg::ST_DIV) |-> (filled_ff && rem_ff < ws_ff))
      else $error("Divider remainder out of range or division before the window is full.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !full_ff) |-> (mean_ff == '0))
      else $error("Non-zero mean reported before the window is full.");

endmodule
